// ===== rtl/sqlf_pkg.sv =====
// sqlf_pkg: shared types and operation codes for the store queue
// no dependencies
`timescale 1ns / 1ps

package sqlf_pkg;

    localparam logic [1:0] OP_STORE  = 2'd0;
    localparam logic [1:0] OP_LOAD   = 2'd1;
    localparam logic [1:0] OP_RETIRE = 2'd2;

    // classified item handed from front to back
    typedef struct packed {
        logic [1:0]  op;
        logic [63:0] addr;
        logic [3:0]  size;
        logic [63:0] data;
    } t_cmd;

endpackage

// ===== rtl/sqlf_front.sv =====
// sqlf_front: accepts commands, saturates size, widens address, masks data, holds a
// two-entry command queue toward the back end; depends on sqlf_pkg
`timescale 1ns / 1ps

module sqlf_front #(
    parameter int ADDR_BITS = 48,
    parameter int MAX_BYTES = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [1:0]       i_operation,
    input  logic [ADDR_BITS-1:0] i_address,
    input  logic [3:0]       i_access_size,
    input  logic [63:0]      i_store_data,
    output logic             o_cmd_valid,
    output sqlf_pkg::t_cmd   o_cmd,
    input  logic             i_cmd_pop
);
    sqlf_pkg::t_cmd r_q [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    sqlf_pkg::t_cmd w_cmd;
    logic [3:0]     w_size;
    logic           w_push;

    always_comb begin
        w_size = (i_access_size > 4'(MAX_BYTES)) ? 4'(MAX_BYTES) : i_access_size;
        w_cmd.op   = i_operation;
        w_cmd.addr = 64'(i_address);
        w_cmd.size = w_size;
        for (int b = 0; b < 8; b++) begin
            w_cmd.data[8*b +: 8] = (4'(b) < w_size) ? i_store_data[8*b +: 8] : 8'h00;
        end
    end

    assign busy        = (r_cnt == 2'd2);
    assign w_push      = start && !busy;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (i_cmd_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_cmd_pop);
        end
        if (w_push) r_q[r_wp] <= w_cmd;
    end
endmodule

// ===== rtl/sqlf_back.sv =====
// sqlf_back: store queue entries, parallel load forwarding and retire compaction
// depends on sqlf_pkg
`timescale 1ns / 1ps

module sqlf_back #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    input  sqlf_pkg::t_cmd i_cmd,
    output logic           o_cmd_pop,
    output logic           o_valid,
    output logic           o_hit,
    output logic [63:0]    o_load_data,
    output logic           o_done_ok,
    output logic           o_overflow,
    output logic [4:0]     o_occupancy
);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    logic [63:0] r_addr [QUEUE_DEPTH];
    logic [3:0]  r_size [QUEUE_DEPTH];
    logic [63:0] r_data [QUEUE_DEPTH];
    logic [CW-1:0] r_count;

    logic [QUEUE_DEPTH-1:0] w_cov, w_match, w_live;
    logic [64:0] w_end_ld;
    logic [63:0] w_ld;
    logic        w_found, w_mfound;
    logic [IW-1:0] w_cidx, w_midx;
    logic [QUEUE_DEPTH-1:0] w_hold [8];
    logic [2:0]  w_off [QUEUE_DEPTH][8];

    logic        n_hit;
    logic [63:0] n_load_data;
    logic        n_done_ok;
    logic        n_overflow;
    logic [4:0]  n_occupancy;

    assign o_cmd_pop = i_cmd_valid;
    assign w_end_ld  = {1'b0, i_cmd.addr} + 65'(i_cmd.size);

    // per-entry compare, all entries in parallel
    always_comb begin
        for (int e = 0; e < QUEUE_DEPTH; e++) begin
            logic [64:0] s_end;
            logic [64:0] d;
            s_end = {1'b0, r_addr[e]} + 65'(r_size[e]);
            w_live[e]  = (CW'(e) < r_count);
            w_cov[e]   = w_live[e] && (i_cmd.addr >= r_addr[e]) && (w_end_ld <= s_end);
            w_match[e] = w_live[e] && (r_addr[e] == i_cmd.addr);
            for (int k = 0; k < 8; k++) begin
                d = {1'b0, i_cmd.addr} + 65'(k) - {1'b0, r_addr[e]};
                w_hold[k][e] = w_live[e] && (4'(k) < i_cmd.size) &&
                               ({1'b0, i_cmd.addr} + 65'(k) >= {1'b0, r_addr[e]}) &&
                               (d < 65'(r_size[e]));
                w_off[e][k] = d[2:0];
            end
        end
    end

    // newest covering entry, oldest matching entry
    always_comb begin
        w_found = 1'b0; w_cidx = '0; w_mfound = 1'b0; w_midx = '0;
        for (int e = 0; e < QUEUE_DEPTH; e++) begin
            if (w_cov[e]) begin w_found = 1'b1; w_cidx = IW'(e); end
        end
        for (int e = QUEUE_DEPTH - 1; e >= 0; e--) begin
            if (w_match[e]) begin w_mfound = 1'b1; w_midx = IW'(e); end
        end
    end

    // byte select: newest holder at or after the covering entry
    always_comb begin
        w_ld = '0;
        for (int k = 0; k < 8; k++) begin
            for (int e = 0; e < QUEUE_DEPTH; e++) begin
                if (w_hold[k][e] && (IW'(e) >= w_cidx))
                    w_ld[8*k +: 8] = r_data[e][8*w_off[e][k] +: 8];
            end
        end
    end

    always_comb begin
        n_hit       = 1'b0;
        n_load_data = '0;
        n_done_ok   = 1'b0;
        n_overflow  = 1'b0;
        n_occupancy = 5'(r_count);
        case (i_cmd.op)
            sqlf_pkg::OP_STORE: begin
                if (r_count < CW'(QUEUE_DEPTH)) begin
                    n_done_ok   = 1'b1;
                    n_occupancy = 5'(r_count + 1'b1);
                end else begin
                    n_overflow = 1'b1;
                end
            end
            sqlf_pkg::OP_LOAD: begin
                n_hit       = w_found;
                n_load_data = w_found ? w_ld : 64'd0;
            end
            sqlf_pkg::OP_RETIRE: begin
                if (w_mfound) begin
                    n_done_ok   = 1'b1;
                    n_occupancy = 5'(r_count - 1'b1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd_valid;
            if (i_cmd_valid) begin
                case (i_cmd.op)
                    sqlf_pkg::OP_STORE: begin
                        if (r_count < CW'(QUEUE_DEPTH)) r_count <= r_count + 1'b1;
                    end
                    sqlf_pkg::OP_RETIRE: begin
                        if (w_mfound) r_count <= r_count - 1'b1;
                    end
                    default: ;
                endcase
            end
        end
        if (i_cmd_valid) begin
            o_hit       <= n_hit;
            o_load_data <= n_load_data;
            o_done_ok   <= n_done_ok;
            o_overflow  <= n_overflow;
            o_occupancy <= n_occupancy;
            case (i_cmd.op)
                sqlf_pkg::OP_STORE: begin
                    if (r_count < CW'(QUEUE_DEPTH)) begin
                        r_addr[r_count[IW-1:0]] <= i_cmd.addr;
                        r_size[r_count[IW-1:0]] <= i_cmd.size;
                        r_data[r_count[IW-1:0]] <= i_cmd.data;
                    end
                end
                sqlf_pkg::OP_RETIRE: begin
                    if (w_mfound) begin
                        for (int e = 0; e < QUEUE_DEPTH - 1; e++) begin
                            if (IW'(e) >= w_midx) begin
                                r_addr[e] <= r_addr[e+1];
                                r_size[e] <= r_size[e+1];
                                r_data[e] <= r_data[e+1];
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

// ===== rtl/store_queue_load_forwarding.sv =====
// Store queue with store-to-load forwarding. A command is taken when start is
// high and busy low; each command gives one result, shown for one cycle with
// o_valid high once it has passed the command queue and the back end's output
// registers, and the receiver cannot stall it.
// The block takes one command per cycle: a two-entry command queue feeds the
// entry array, which compares all entries in parallel for each command.
`timescale 1ns / 1ps

module store_queue_load_forwarding #(
    parameter int QUEUE_DEPTH = 16,
    parameter int MAX_BYTES   = 8,
    parameter int ADDR_BITS   = 48
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           i_operation,
    input  logic [ADDR_BITS-1:0] i_address,
    input  logic [3:0]           i_access_size,
    input  logic [63:0]          i_store_data,
    output logic                 o_valid,
    output logic                 o_hit,
    output logic [63:0]          o_load_data,
    output logic                 o_done_ok,
    output logic                 o_overflow,
    output logic [4:0]           o_occupancy
);
    logic           w_cmd_valid, w_cmd_pop;
    sqlf_pkg::t_cmd w_cmd;

    sqlf_front #(.ADDR_BITS(ADDR_BITS), .MAX_BYTES(MAX_BYTES)) u_front (
        .i_clk, .i_rst_n, .start, .busy, .i_operation, .i_address,
        .i_access_size, .i_store_data,
        .o_cmd_valid(w_cmd_valid), .o_cmd(w_cmd), .i_cmd_pop(w_cmd_pop)
    );

    sqlf_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
        .i_clk, .i_rst_n, .i_cmd_valid(w_cmd_valid), .i_cmd(w_cmd),
        .o_cmd_pop(w_cmd_pop), .o_valid, .o_hit, .o_load_data, .o_done_ok,
        .o_overflow, .o_occupancy
    );
endmodule

// ===== rtl/sqlf_checker.sv =====
// sqlf_checker: port-level assertions for the store queue
// bound to store_queue_load_forwarding
`timescale 1ns / 1ps

module sqlf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        o_hit,
    input logic [63:0] o_load_data,
    input logic        o_done_ok,
    input logic        o_overflow,
    input logic [4:0]  o_occupancy
);
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_done_ok && o_overflow) && !(o_hit && (o_done_ok || o_overflow)))
        else $error("conflicting result flags");
    a_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hit) |-> (o_load_data == 64'd0))
        else $error("load data on miss");
    a_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_overflow) |-> (o_occupancy == 5'd16))
        else $error("overflow below full");
    a_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_occupancy <= 5'd16))
        else $error("occupancy beyond depth");
endmodule

bind store_queue_load_forwarding sqlf_checker u_sqlf_checker (.*);

// ===== tb/store_queue_load_forwarding_tb.sv =====
// store_queue_load_forwarding_tb: directed table plus random stores, loads and retires
// checked against a behavioral copy of the queue; depends on sqlf_pkg and the dut
`timescale 1ns / 1ps

module store_queue_load_forwarding_tb;

    localparam int DEPTH = 16;
    localparam int NB    = 8;
    localparam int AW    = 48;
    localparam logic [1:0] OP_NONE = 2'd3;

    typedef struct packed {
        logic        hit;
        logic [63:0] ldata;
        logic        ok;
        logic        ovf;
        logic [4:0]  occ;
    } t_res;

    typedef struct {
        logic [1:0]    op;
        logic [AW-1:0] addr;
        logic [3:0]    size;
        logic [63:0]   data;
        logic          typed;
        t_res          res;
    } t_row;

    logic i_clk = 1'b0, i_rst_n = 1'b0, start = 1'b0;
    logic busy;
    logic [1:0] i_operation = '0;
    logic [AW-1:0] i_address = '0;
    logic [3:0] i_access_size = '0;
    logic [63:0] i_store_data = '0;
    logic o_valid, o_hit, o_done_ok, o_overflow;
    logic [63:0] o_load_data;
    logic [4:0] o_occupancy;

    store_queue_load_forwarding dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow queue, index 0 oldest
    logic [AW-1:0] sq_addr [DEPTH];
    int            sq_size [DEPTH];
    logic [63:0]   sq_data [DEPTH];
    int            sq_count = 0;

    t_res pending_results[$];
    t_row rows[$];
    int   errors = 0;
    int   idle_pct = 0;
    logic [AW-1:0] addr_pool [8];

    function automatic void add_row(t_row row);
        rows.insert(rows.size(), row);
    endfunction

    function automatic bit entry_covers(int e, logic [AW-1:0] a, int n);
        longint unsigned off;
        if (a < sq_addr[e]) return 0;
        off = a - sq_addr[e];
        if (off > sq_size[e]) return 0;
        return n <= sq_size[e] - off;
    endfunction

    function automatic int byte_offset(int e, logic [AW-1:0] a, int k);
        longint unsigned d;
        longint o;
        if (a >= sq_addr[e]) begin
            d = a - sq_addr[e];
            if (d >= sq_size[e]) return -1;
            o = d + k;
        end else begin
            d = sq_addr[e] - a;
            if (d > k) return -1;
            o = k - d;
        end
        return (o >= sq_size[e]) ? -1 : int'(o);
    endfunction

    function automatic t_res forward_step(logic [1:0] op, logic [AW-1:0] a,
                                          logic [3:0] sz, logic [63:0] sd);
        t_res r;
        int n, cov, off;
        r = '0;
        n = (sz > NB) ? NB : sz;
        case (op)
            sqlf_pkg::OP_STORE: begin
                if (sq_count >= DEPTH) r.ovf = 1'b1;
                else begin
                    sq_addr[sq_count] = a;
                    sq_size[sq_count] = n;
                    sq_data[sq_count] = (n >= 8) ? sd : sd & ((64'd1 << (8 * n)) - 1);
                    sq_count++;
                    r.ok = 1'b1;
                end
            end
            sqlf_pkg::OP_LOAD: begin
                cov = -1;
                for (int i = sq_count - 1; i >= 0; i--)
                    if (cov < 0 && entry_covers(i, a, n)) cov = i;
                if (cov >= 0) begin
                    r.hit = 1'b1;
                    for (int k = 0; k < n; k++) begin
                        for (int j = sq_count - 1; j >= cov; j--) begin
                            off = byte_offset(j, a, k);
                            if (off >= 0) begin
                                r.ldata[8*k +: 8] = sq_data[j][8*off +: 8];
                                break;
                            end
                        end
                    end
                end
            end
            sqlf_pkg::OP_RETIRE: begin
                for (int i = 0; i < sq_count; i++) begin
                    if (sq_addr[i] == a) begin
                        for (int j = i; j + 1 < sq_count; j++) begin
                            sq_addr[j] = sq_addr[j+1];
                            sq_size[j] = sq_size[j+1];
                            sq_data[j] = sq_data[j+1];
                        end
                        sq_count--;
                        r.ok = 1'b1;
                        break;
                    end
                end
            end
            default: ;
        endcase
        r.occ = sq_count[4:0];
        return r;
    endfunction

    // one transfer per call; start stays high across back-to-back items
    task automatic send_cmd(logic [1:0] op, logic [AW-1:0] a, logic [3:0] sz,
                            logic [63:0] sd, bit typed, t_res typed_res);
        t_res r;
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_operation <= op;
        i_address <= a;
        i_access_size <= sz;
        i_store_data <= sd;
        do @(posedge i_clk); while (busy);
        r = forward_step(op, a, sz, sd);
        if (typed && r !== typed_res) begin
            $display("%0t: table row expected %h model %h", $time, typed_res, r);
            errors++;
        end
        pending_results.insert(pending_results.size(), r);
    endtask

    always @(posedge i_clk) begin
        t_res got, want;
        if (i_rst_n && o_valid) begin
            got = '{o_hit, o_load_data, o_done_ok, o_overflow, o_occupancy};
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (got.hit !== want.hit || got.ldata !== want.ldata ||
                    got.ok !== want.ok || got.ovf !== want.ovf || got.occ !== want.occ) begin
                    $display("%0t: expected %h actual %h", $time, want, got);
                    errors++;
                end
            end
        end
    end

    function automatic t_res mk(logic h, logic [63:0] d, logic ok, logic ov, int occ);
        t_res r;
        r = '{h, d, ok, ov, occ[4:0]};
        return r;
    endfunction

    initial begin
        logic [1:0] op;
        logic [AW-1:0] a;
        int pick, p;
        logic [AW-1:0] top;
        top = {AW{1'b1}};
        // directed table
        add_row('{sqlf_pkg::OP_LOAD,   0,      4'd8, 0, 1, mk(0, 0, 0, 0, 0)});
        add_row('{sqlf_pkg::OP_RETIRE, 0,      4'd1, 0, 1, mk(0, 0, 0, 0, 0)});
        add_row('{OP_NONE,             top,    4'd15, '1, 1, mk(0, 0, 0, 0, 0)});
        add_row('{sqlf_pkg::OP_STORE,  'h100,  4'd8, 64'h8877665544332211, 1,
                  mk(0, 0, 1, 0, 1)});
        add_row('{sqlf_pkg::OP_LOAD,   'h100,  4'd8, '1, 1,
                  mk(1, 64'h8877665544332211, 0, 0, 1)});
        add_row('{sqlf_pkg::OP_STORE,  'h102,  4'd2, 64'hffff_ffff_ffff_aabb, 0, '0});
        add_row('{sqlf_pkg::OP_LOAD,   'h101,  4'd4, 0, 0, '0});
        add_row('{sqlf_pkg::OP_LOAD,   'h102,  4'd15, 0, 0, '0});
        add_row('{sqlf_pkg::OP_STORE,  'h108,  4'd0, '1, 0, '0});
        add_row('{sqlf_pkg::OP_LOAD,   'h108,  4'd0, 0, 0, '0});
        add_row('{sqlf_pkg::OP_LOAD,   'h10a,  4'd0, 0, 0, '0});
        add_row('{sqlf_pkg::OP_LOAD,   'h106,  4'd4, 0, 0, '0});
        add_row('{sqlf_pkg::OP_STORE,  top - 7, 4'd15, '1, 0, '0});
        add_row('{sqlf_pkg::OP_LOAD,   top,    4'd1, 0, 0, '0});
        add_row('{sqlf_pkg::OP_LOAD,   top,    4'd2, 0, 0, '0});
        add_row('{sqlf_pkg::OP_RETIRE, 'h102,  4'd0, 0, 0, '0});
        add_row('{sqlf_pkg::OP_RETIRE, 'h555,  4'd0, 0, 0, '0});
        for (int i = 0; i < 14; i++)
            add_row('{sqlf_pkg::OP_STORE, 'h200 + i, 4'd1, 64'(i), 0, '0});
        add_row('{sqlf_pkg::OP_STORE, 'h300, 4'd1, 0, 0, '0});
        add_row('{sqlf_pkg::OP_LOAD,  'h20d, 4'd1, 0, 0, '0});
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (rows[i])
            send_cmd(rows[i].op, rows[i].addr, rows[i].size, rows[i].data,
                     rows[i].typed, rows[i].res);
        for (int i = 0; i < DEPTH; i++)
            send_cmd(sqlf_pkg::OP_RETIRE, (i < 2) ? 'h100 + 8 * i : 'h200 + i - 2,
                     0, 0, 0, '0);
        send_cmd(sqlf_pkg::OP_RETIRE, top - 7, 0, 0, 0, '0);
        // random part: clustered addresses so loads overlap stores
        for (int phase = 0; phase < 4; phase++) begin
            idle_pct = (phase == 1) ? 58 : (phase == 3) ? 10 : 0;
            for (int i = 0; i < 8; i++)
                addr_pool[i] = {$urandom, $urandom} & top;
            for (int i = 0; i < 200; i++) begin
                pick = $urandom_range(99);
                op = (pick < 40) ? sqlf_pkg::OP_STORE : (pick < 75) ? sqlf_pkg::OP_LOAD :
                     (pick < 97) ? sqlf_pkg::OP_RETIRE : OP_NONE;
                if ($urandom_range(9) == 0) a = {$urandom, $urandom} & top;
                else begin
                    p = $urandom_range(7);
                    a = addr_pool[p] + $urandom_range(12);
                    if (op == sqlf_pkg::OP_RETIRE && sq_count > 0 && $urandom_range(1))
                        a = sq_addr[$urandom_range(sq_count - 1)];
                end
                send_cmd(op, a, $urandom_range(15), {$urandom, $urandom}, 0, '0);
            end
        end
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("store_queue_load_forwarding: match");
        else
            $display("store_queue_load_forwarding: mismatch");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("store_queue_load_forwarding: mismatch");
        $finish;
    end

endmodule
